>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers, reset-qualified on rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

>>> rtl/bgsc_pkg.sv
// ----------------------------------------------------------------------------
// Battery gauge status classifier package
// Shared types, status codes, register indexes and fixed thresholds.
// ----------------------------------------------------------------------------
package bgsc_pkg;

  localparam int unsigned MvW   = 13;
  localparam int unsigned SocW  = 14;
  localparam int unsigned RateW = 16;
  localparam int unsigned DbW   = 15;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;

  localparam logic [MvW-1:0]  NO_CELL_MV  = 13'd2000;
  localparam logic [MvW-1:0]  LOW_CELL_MV = 13'd2500;
  localparam logic [MvW-1:0]  USB_HEUR_MV = 13'd4150;
  localparam logic [SocW-1:0] SOC_FULL    = 14'd10000;

  typedef enum logic [3:0] {
    ST_NOT_PRESENT = 4'd0,
    ST_CHARGING    = 4'd1,
    ST_FULL        = 4'd2,
    ST_HIGH        = 4'd3,
    ST_GOOD        = 4'd4,
    ST_MEDIUM      = 4'd5,
    ST_LOW         = 4'd6,
    ST_CRITICAL    = 4'd7,
    ST_EMPTY       = 4'd8,
    ST_UNKNOWN     = 4'd9
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BAND_FULL     = 3'd0,
    REG_BAND_HIGH     = 3'd1,
    REG_BAND_GOOD     = 3'd2,
    REG_BAND_MEDIUM   = 3'd3,
    REG_BAND_LOW      = 3'd4,
    REG_BAND_CRITICAL = 3'd5,
    REG_RATE_DEADBAND = 3'd6,
    REG_VBUS_FITTED   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [MvW-1:0] band_full_mv;
    logic [MvW-1:0] band_high_mv;
    logic [MvW-1:0] band_good_mv;
    logic [MvW-1:0] band_medium_mv;
    logic [MvW-1:0] band_low_mv;
    logic [MvW-1:0] band_critical_mv;
    logic [DbW-1:0] rate_deadband;
    logic           vbus_pin_fitted;
  } cfg_t;

  typedef struct packed {
    logic                    gauge_present;
    logic                    read_ok;
    logic [MvW-1:0]          cell_mv;
    logic [SocW-1:0]         soc_centi;
    logic signed [RateW-1:0] rate_centi;
    logic                    vbus_level;
  } item_t;

  typedef struct packed {
    status_e         status;
    logic            charging;
    logic            usb_present;
    logic [MvW-1:0]  batt_mv;
    logic [SocW-1:0] soc_reported;
    logic            note_usb_on;
    logic            note_usb_off;
    logic            note_low;
    logic            note_critical;
  } result_t;

endpackage

>>> rtl/bgsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register file for voltage bands, rate deadband and VBUS mode.
// ----------------------------------------------------------------------------
module bgsc_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bgsc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [bgsc_pkg::CfgDataW-1:0]      cfg_data_i,
  output bgsc_pkg::cfg_t                     cfg_o
);

  bgsc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (bgsc_pkg::cfg_idx_e'(cfg_idx_i))
        bgsc_pkg::REG_BAND_FULL:     cfg_d.band_full_mv     = cfg_data_i[12:0];
        bgsc_pkg::REG_BAND_HIGH:     cfg_d.band_high_mv     = cfg_data_i[12:0];
        bgsc_pkg::REG_BAND_GOOD:     cfg_d.band_good_mv     = cfg_data_i[12:0];
        bgsc_pkg::REG_BAND_MEDIUM:   cfg_d.band_medium_mv   = cfg_data_i[12:0];
        bgsc_pkg::REG_BAND_LOW:      cfg_d.band_low_mv      = cfg_data_i[12:0];
        bgsc_pkg::REG_BAND_CRITICAL: cfg_d.band_critical_mv = cfg_data_i[12:0];
        bgsc_pkg::REG_RATE_DEADBAND: cfg_d.rate_deadband    = cfg_data_i[14:0];
        bgsc_pkg::REG_VBUS_FITTED:   cfg_d.vbus_pin_fitted  = cfg_data_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.band_full_mv     <= 13'd4150;
      cfg_q.band_high_mv     <= 13'd4000;
      cfg_q.band_good_mv     <= 13'd3850;
      cfg_q.band_medium_mv   <= 13'd3700;
      cfg_q.band_low_mv      <= 13'd3500;
      cfg_q.band_critical_mv <= 13'd3300;
      cfg_q.rate_deadband    <= 15'd50;
      cfg_q.vbus_pin_fitted  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/bgsc_state.sv
// ----------------------------------------------------------------------------
// Gauge state and classification
// Holds the gauge reading and flags, computes status and notes per tick.
// ----------------------------------------------------------------------------
module bgsc_state (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  bgsc_pkg::cfg_t   cfg_i,
  input  bgsc_pkg::item_t  item_i,
  output bgsc_pkg::result_t res_o
);

  logic                          gauge_found_q, gauge_found_d;
  logic                          chg_q, chg_d;
  logic                          usb_q, usb_d;
  logic [bgsc_pkg::MvW-1:0]      mv_q, mv_d;
  logic [bgsc_pkg::SocW-1:0]     soc_q, soc_d;
  bgsc_pkg::status_e             status_q, status_d;

  logic signed [bgsc_pkg::RateW:0] rate_ext, db_pos, db_neg;
  logic                            rate_above, rate_below;
  logic [bgsc_pkg::SocW-1:0]       soc_sat;
  logic                            chg_rate;
  bgsc_pkg::status_e               ladder;
  logic                            prev_known, was_chg, is_chg;
  logic                            was_crit, is_crit;

  assign rate_ext   = {item_i.rate_centi[bgsc_pkg::RateW-1], item_i.rate_centi};
  assign db_pos     = $signed({2'b00, cfg_i.rate_deadband});
  assign db_neg     = -db_pos;
  assign rate_above = rate_ext > db_pos;
  assign rate_below = rate_ext < db_neg;
  assign soc_sat    = (item_i.soc_centi > bgsc_pkg::SOC_FULL) ? bgsc_pkg::SOC_FULL
                                                              : item_i.soc_centi;
  assign chg_rate   = rate_above ? 1'b1 : (rate_below ? 1'b0 : chg_q);

  always_comb begin
    gauge_found_d = gauge_found_q | item_i.gauge_present;
    chg_d         = chg_q;
    usb_d         = usb_q;
    mv_d          = mv_q;
    soc_d         = soc_q;
    if (!gauge_found_d) begin
      mv_d  = '0;
      soc_d = '0;
      chg_d = 1'b0;
      usb_d = cfg_i.vbus_pin_fitted ? item_i.vbus_level : 1'b1;
    end else if (item_i.read_ok) begin
      mv_d  = item_i.cell_mv;
      soc_d = soc_sat;
      if (cfg_i.vbus_pin_fitted) begin
        usb_d = item_i.vbus_level;
        chg_d = item_i.vbus_level & chg_rate;
      end else begin
        chg_d = chg_rate;
        usb_d = rate_above | (item_i.cell_mv > bgsc_pkg::USB_HEUR_MV);
      end
      if (usb_d && !chg_d && (item_i.cell_mv >= cfg_i.band_full_mv)) begin
        soc_d = bgsc_pkg::SOC_FULL;
      end
    end
  end

  always_comb begin
    if (mv_d < bgsc_pkg::NO_CELL_MV)            ladder = bgsc_pkg::ST_NOT_PRESENT;
    else if (usb_d)                             ladder = bgsc_pkg::ST_CHARGING;
    else if (mv_d >= cfg_i.band_full_mv)        ladder = bgsc_pkg::ST_FULL;
    else if (mv_d >= cfg_i.band_high_mv)        ladder = bgsc_pkg::ST_HIGH;
    else if (mv_d >= cfg_i.band_good_mv)        ladder = bgsc_pkg::ST_GOOD;
    else if (mv_d >= cfg_i.band_medium_mv)      ladder = bgsc_pkg::ST_MEDIUM;
    else if (mv_d >= cfg_i.band_low_mv)         ladder = bgsc_pkg::ST_LOW;
    else if (mv_d >= cfg_i.band_critical_mv)    ladder = bgsc_pkg::ST_CRITICAL;
    else                                        ladder = bgsc_pkg::ST_EMPTY;
  end

  assign prev_known = (status_q != bgsc_pkg::ST_UNKNOWN);
  assign was_chg    = (status_q == bgsc_pkg::ST_CHARGING);
  assign is_chg     = (ladder == bgsc_pkg::ST_CHARGING);
  assign was_crit   = (status_q == bgsc_pkg::ST_CRITICAL) || (status_q == bgsc_pkg::ST_EMPTY);
  assign is_crit    = (ladder == bgsc_pkg::ST_CRITICAL) || (ladder == bgsc_pkg::ST_EMPTY);

  always_comb begin
    res_o.note_usb_on   = 1'b0;
    res_o.note_usb_off  = 1'b0;
    res_o.note_low      = 1'b0;
    res_o.note_critical = 1'b0;
    if ((mv_d >= bgsc_pkg::LOW_CELL_MV) || !prev_known) begin
      status_d = ladder;
      if (prev_known) begin
        res_o.note_usb_on   = is_chg & ~was_chg;
        res_o.note_usb_off  = ~is_chg & was_chg;
        res_o.note_low      = (ladder == bgsc_pkg::ST_LOW) &&
                              (status_q != bgsc_pkg::ST_LOW);
        res_o.note_critical = is_crit & ~was_crit;
      end
    end else begin
      status_d = bgsc_pkg::ST_NOT_PRESENT;
    end
    res_o.status       = status_d;
    res_o.charging     = chg_d;
    res_o.usb_present  = usb_d;
    res_o.batt_mv      = mv_d;
    res_o.soc_reported = soc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gauge_found_q <= 1'b0;
      chg_q         <= 1'b0;
      usb_q         <= 1'b0;
      mv_q          <= '0;
      soc_q         <= '0;
      status_q      <= bgsc_pkg::ST_UNKNOWN;
    end else if (adv_i) begin
      gauge_found_q <= gauge_found_d;
      chg_q         <= chg_d;
      usb_q         <= usb_d;
      mv_q          <= mv_d;
      soc_q         <= soc_d;
      status_q      <= status_d;
    end
  end

endmodule

>>> rtl/battery_gauge_status_classifier.sv
// ----------------------------------------------------------------------------
// Battery gauge status classifier
// Per poll tick: gauge reading hold, USB and charging flags, voltage-ladder
// status and edge notifications.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | gauge/read/mv/soc/rate/vbus
//   out     | output    | out_valid_o/out_ready_i | status, flags, mv, soc, notes
//   cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// An accepted poll passes through the input register and then the result
// register; throughput is one transaction per cycle while the receiver does
// not stall, with the state update sitting between the two registers.
// Reset restores default bands and clears all gauge state; status is unknown.
// A stalled result holds the input register; in_ready_o then drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module battery_gauge_status_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bgsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bgsc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          gauge_present_i,
  input  logic                          read_ok_i,
  input  logic [12:0]                   cell_mv_i,
  input  logic [13:0]                   soc_centi_i,
  input  logic signed [15:0]            rate_centi_i,
  input  logic                          vbus_level_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [3:0]                    status_o,
  output logic                          charging_o,
  output logic                          usb_present_o,
  output logic [12:0]                   batt_mv_o,
  output logic [13:0]                   soc_reported_o,
  output logic                          note_usb_on_o,
  output logic                          note_usb_off_o,
  output logic                          note_low_o,
  output logic                          note_critical_o
);

  bgsc_pkg::cfg_t    cfg;
  bgsc_pkg::item_t   in_item_q;
  bgsc_pkg::result_t res, out_res_q;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              adv;

  bgsc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign adv        = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q.gauge_present <= gauge_present_i;
      in_item_q.read_ok       <= read_ok_i;
      in_item_q.cell_mv       <= cell_mv_i;
      in_item_q.soc_centi     <= soc_centi_i;
      in_item_q.rate_centi    <= rate_centi_i;
      in_item_q.vbus_level    <= vbus_level_i;
    end
  end

  bgsc_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .cfg_i  (cfg),
    .item_i (in_item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (~out_valid_q | out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_res_q.status;
  assign charging_o      = out_res_q.charging;
  assign usb_present_o   = out_res_q.usb_present;
  assign batt_mv_o       = out_res_q.batt_mv;
  assign soc_reported_o  = out_res_q.soc_reported;
  assign note_usb_on_o   = out_res_q.note_usb_on;
  assign note_usb_off_o  = out_res_q.note_usb_off;
  assign note_low_o      = out_res_q.note_low;
  assign note_critical_o = out_res_q.note_critical;

  `ASSERT_CLK(a_stall_full, !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i, "stall")
  `ASSERT_CLK(a_usb_on_chg, out_valid_o && note_usb_on_o |-> status_o == bgsc_pkg::ST_CHARGING, "on")
  `ASSERT_CLK(a_low_status, out_valid_o && note_low_o |-> status_o == bgsc_pkg::ST_LOW, "low note")
  `ASSERT_CLK(a_crit_status, out_valid_o && note_critical_o |-> status_o >= bgsc_pkg::ST_CRITICAL, "crit")
  `ASSERT_NEVER(a_usb_on_off, out_valid_o && note_usb_on_o && note_usb_off_o, "usb on and off")

endmodule

>>> verif/tb_battery_gauge_status_classifier.sv
// ----------------------------------------------------------------------------
// Battery gauge status classifier testbench
// Drives poll ticks through the valid/ready input channel with bursty gaps
// and collects results under a randomly stalling receiver. Every result is
// compared field by field with a table value or an in-bench classifier model.
// A short directed table opens the run; randomized phases follow, each under
// its own band, deadband and VBUS settings, written while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_battery_gauge_status_classifier;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseItems  = 145;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned SettleCycles = 4;
  localparam bgsc_pkg::cfg_idx_e NoIdx = bgsc_pkg::REG_BAND_FULL;

  typedef struct {
    bit                            is_cfg;
    bgsc_pkg::cfg_idx_e            idx;
    logic [bgsc_pkg::CfgDataW-1:0] data;
    bgsc_pkg::item_t               poll;
    bit                            typed;
    bgsc_pkg::result_t             want;
  } tab_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [bgsc_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [bgsc_pkg::CfgDataW-1:0] cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic                          gauge_present_i;
  logic                          read_ok_i;
  logic [12:0]                   cell_mv_i;
  logic [13:0]                   soc_centi_i;
  logic signed [15:0]            rate_centi_i;
  logic                          vbus_level_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [3:0]                    status_o;
  logic                          charging_o;
  logic                          usb_present_o;
  logic [12:0]                   batt_mv_o;
  logic [13:0]                   soc_reported_o;
  logic                          note_usb_on_o;
  logic                          note_usb_off_o;
  logic                          note_low_o;
  logic                          note_critical_o;

  battery_gauge_status_classifier i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .gauge_present_i(gauge_present_i),
    .read_ok_i      (read_ok_i),
    .cell_mv_i      (cell_mv_i),
    .soc_centi_i    (soc_centi_i),
    .rate_centi_i   (rate_centi_i),
    .vbus_level_i   (vbus_level_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .charging_o     (charging_o),
    .usb_present_o  (usb_present_o),
    .batt_mv_o      (batt_mv_o),
    .soc_reported_o (soc_reported_o),
    .note_usb_on_o  (note_usb_on_o),
    .note_usb_off_o (note_usb_off_o),
    .note_low_o     (note_low_o),
    .note_critical_o(note_critical_o)
  );

  always #4 clk_i = ~clk_i;

  // Model state and register shadow
  bgsc_pkg::cfg_t            band_cfg;
  logic                      gauge_seen;
  logic                      chg_state;
  logic                      usb_state;
  logic [bgsc_pkg::MvW-1:0]  mv_held;
  logic [bgsc_pkg::SocW-1:0] soc_held;
  bgsc_pkg::status_e         status_held;

  bgsc_pkg::result_t pending_results[$];
  bgsc_pkg::result_t want;
  tab_row_t          dir_tab[$];
  int unsigned       mismatch_cnt = 0;
  int unsigned       cycle_cnt = 0;
  int unsigned       burst_left = 0;
  int                walk_mv = 3800;
  bit                long_hold = 1'b0;

  function automatic bgsc_pkg::status_e band_ladder();
    if (mv_held < bgsc_pkg::NO_CELL_MV) return bgsc_pkg::ST_NOT_PRESENT;
    if (usb_state) return bgsc_pkg::ST_CHARGING;
    if (mv_held >= band_cfg.band_full_mv) return bgsc_pkg::ST_FULL;
    if (mv_held >= band_cfg.band_high_mv) return bgsc_pkg::ST_HIGH;
    if (mv_held >= band_cfg.band_good_mv) return bgsc_pkg::ST_GOOD;
    if (mv_held >= band_cfg.band_medium_mv) return bgsc_pkg::ST_MEDIUM;
    if (mv_held >= band_cfg.band_low_mv) return bgsc_pkg::ST_LOW;
    if (mv_held >= band_cfg.band_critical_mv) return bgsc_pkg::ST_CRITICAL;
    return bgsc_pkg::ST_EMPTY;
  endfunction

  function automatic bgsc_pkg::result_t predict_status(bgsc_pkg::item_t it);
    bgsc_pkg::result_t r;
    bgsc_pkg::status_e prev;
    bgsc_pkg::status_e now;
    int                rate;
    int                db;
    r    = '0;
    prev = status_held;
    if (!gauge_seen) gauge_seen = it.gauge_present;
    if (!gauge_seen) begin
      mv_held   = '0;
      soc_held  = '0;
      chg_state = 1'b0;
      usb_state = band_cfg.vbus_pin_fitted ? it.vbus_level : 1'b1;
    end else if (it.read_ok) begin
      rate     = int'(it.rate_centi);
      db       = int'(band_cfg.rate_deadband);
      mv_held  = it.cell_mv;
      soc_held = (it.soc_centi > bgsc_pkg::SOC_FULL) ? bgsc_pkg::SOC_FULL : it.soc_centi;
      if (band_cfg.vbus_pin_fitted) begin
        usb_state = it.vbus_level;
        if (!usb_state) chg_state = 1'b0;
        else if (rate > db) chg_state = 1'b1;
        else if (rate < -db) chg_state = 1'b0;
      end else begin
        if (rate > db) chg_state = 1'b1;
        else if (rate < -db) chg_state = 1'b0;
        usb_state = (rate > db) || (it.cell_mv > bgsc_pkg::USB_HEUR_MV);
      end
      if (usb_state && !chg_state && mv_held >= band_cfg.band_full_mv) begin
        soc_held = bgsc_pkg::SOC_FULL;
      end
    end
    if (mv_held >= bgsc_pkg::LOW_CELL_MV || prev == bgsc_pkg::ST_UNKNOWN) begin
      now = band_ladder();
      if (prev != bgsc_pkg::ST_UNKNOWN) begin
        r.note_usb_on   = (now == bgsc_pkg::ST_CHARGING) && (prev != bgsc_pkg::ST_CHARGING);
        r.note_usb_off  = (now != bgsc_pkg::ST_CHARGING) && (prev == bgsc_pkg::ST_CHARGING);
        r.note_low      = (now == bgsc_pkg::ST_LOW) && (prev != bgsc_pkg::ST_LOW);
        r.note_critical = (now == bgsc_pkg::ST_CRITICAL || now == bgsc_pkg::ST_EMPTY) &&
                          prev != bgsc_pkg::ST_CRITICAL && prev != bgsc_pkg::ST_EMPTY;
      end
    end else begin
      now = bgsc_pkg::ST_NOT_PRESENT;
    end
    status_held    = now;
    r.status       = now;
    r.charging     = chg_state;
    r.usb_present  = usb_state;
    r.batt_mv      = mv_held;
    r.soc_reported = soc_held;
    return r;
  endfunction

  function automatic void shadow_write(bgsc_pkg::cfg_idx_e idx,
                                       logic [bgsc_pkg::CfgDataW-1:0] d);
    case (idx)
      bgsc_pkg::REG_BAND_FULL:     band_cfg.band_full_mv     = d[bgsc_pkg::MvW-1:0];
      bgsc_pkg::REG_BAND_HIGH:     band_cfg.band_high_mv     = d[bgsc_pkg::MvW-1:0];
      bgsc_pkg::REG_BAND_GOOD:     band_cfg.band_good_mv     = d[bgsc_pkg::MvW-1:0];
      bgsc_pkg::REG_BAND_MEDIUM:   band_cfg.band_medium_mv   = d[bgsc_pkg::MvW-1:0];
      bgsc_pkg::REG_BAND_LOW:      band_cfg.band_low_mv      = d[bgsc_pkg::MvW-1:0];
      bgsc_pkg::REG_BAND_CRITICAL: band_cfg.band_critical_mv = d[bgsc_pkg::MvW-1:0];
      bgsc_pkg::REG_RATE_DEADBAND: band_cfg.rate_deadband    = d[bgsc_pkg::DbW-1:0];
      bgsc_pkg::REG_VBUS_FITTED:   band_cfg.vbus_pin_fitted  = d[0];
      default: ;
    endcase
  endfunction

  function automatic bgsc_pkg::item_t poll(bit gp, bit ok, int mv, int soc, int rate, bit vbus);
    bgsc_pkg::item_t it;
    it.gauge_present = gp;
    it.read_ok       = ok;
    it.cell_mv       = mv[12:0];
    it.soc_centi     = soc[13:0];
    it.rate_centi    = rate[15:0];
    it.vbus_level    = vbus;
    return it;
  endfunction

  function automatic bgsc_pkg::result_t res(bgsc_pkg::status_e st, bit chg, bit usb, int mv,
                                            int soc, bit on, bit off, bit lo, bit cr);
    bgsc_pkg::result_t r;
    r.status        = st;
    r.charging      = chg;
    r.usb_present   = usb;
    r.batt_mv       = mv[12:0];
    r.soc_reported  = soc[13:0];
    r.note_usb_on   = on;
    r.note_usb_off  = off;
    r.note_low      = lo;
    r.note_critical = cr;
    return r;
  endfunction

  function automatic bgsc_pkg::item_t rand_poll();
    bgsc_pkg::item_t it;
    int              v;
    int              thr;
    int              r;
    int              db;
    int              soc;
    it.gauge_present = ($urandom_range(0, 3) != 0);
    it.read_ok       = ($urandom_range(0, 6) != 0);
    it.vbus_level    = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: v = int'($urandom_range(0, 8191));
      1: v = int'($urandom_range(0, 2600));
      2, 3: begin
        case ($urandom_range(0, 8))
          0: thr = int'(band_cfg.band_full_mv);
          1: thr = int'(band_cfg.band_high_mv);
          2: thr = int'(band_cfg.band_good_mv);
          3: thr = int'(band_cfg.band_medium_mv);
          4: thr = int'(band_cfg.band_low_mv);
          5: thr = int'(band_cfg.band_critical_mv);
          6: thr = int'(bgsc_pkg::NO_CELL_MV);
          7: thr = int'(bgsc_pkg::LOW_CELL_MV);
          default: thr = int'(bgsc_pkg::USB_HEUR_MV);
        endcase
        v = thr + int'($urandom_range(0, 4)) - 2;
      end
      default: begin
        walk_mv = walk_mv + int'($urandom_range(0, 80)) - 40;
        if (walk_mv < 2400) walk_mv = 2400;
        if (walk_mv > 4400) walk_mv = 4400;
        v = walk_mv;
      end
    endcase
    if (v < 0) v = 0;
    if (v > 8191) v = 8191;
    it.cell_mv = v[12:0];
    db = int'(band_cfg.rate_deadband);
    case ($urandom_range(0, 7))
      0: r = int'($urandom_range(0, 65535)) - 32768;
      1, 2: r = (($urandom_range(0, 1) != 0) ? db : -db) + int'($urandom_range(0, 2)) - 1;
      default: r = int'($urandom_range(0, 400)) - 200;
    endcase
    if (r < -32768) r = -32768;
    if (r > 32767) r = 32767;
    it.rate_centi = r[15:0];
    soc = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 16383))
                                      : int'($urandom_range(0, 10000));
    it.soc_centi = soc[13:0];
    return it;
  endfunction

  task automatic chk(string name, logic [15:0] e, logic [15:0] a);
    if (a !== e) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      mismatch_cnt++;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(bgsc_pkg::cfg_idx_e idx, logic [bgsc_pkg::CfgDataW-1:0] d);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_write(idx, d);
  endtask

  task automatic send_item(bgsc_pkg::item_t it, bit typed, bgsc_pkg::result_t fixed);
    int unsigned       gap;
    bgsc_pkg::result_t pred;
    if (burst_left == 0) begin
      case ($urandom_range(0, 19))
        0: gap = $urandom_range(20, 40);
        1, 2, 3, 4, 5: gap = $urandom_range(4, 12);
        default: gap = $urandom_range(0, 3);
      endcase
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    gauge_present_i <= it.gauge_present;
    read_ok_i       <= it.read_ok;
    cell_mv_i       <= it.cell_mv;
    soc_centi_i     <= it.soc_centi;
    rate_centi_i    <= it.rate_centi;
    vbus_level_i    <= it.vbus_level;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pred = predict_status(it);
    pending_results.push_back(typed ? fixed : pred);
    @(negedge clk_i);
  endtask

  task automatic load_phase(int unsigned p);
    bgsc_pkg::cfg_idx_e band_regs[6];
    int                 b[6];
    int                 db;
    bit                 fitted;
    band_regs = '{bgsc_pkg::REG_BAND_FULL, bgsc_pkg::REG_BAND_HIGH, bgsc_pkg::REG_BAND_GOOD,
                  bgsc_pkg::REG_BAND_MEDIUM, bgsc_pkg::REG_BAND_LOW,
                  bgsc_pkg::REG_BAND_CRITICAL};
    case (p)
      0: begin b = '{4150, 4000, 3850, 3700, 3500, 3300}; db = 50; fitted = 1'b0; end
      1: begin b = '{0, 0, 0, 0, 0, 0}; db = 0; fitted = 1'b1; end
      2: begin b = '{8191, 8191, 8191, 8191, 8191, 8191}; db = 32767; fitted = 1'b0; end
      3: begin
        foreach (b[i]) b[i] = int'($urandom_range(0, 5000));
        db     = int'($urandom_range(0, 300));
        fitted = 1'($urandom_range(0, 1));
      end
      4: begin b = '{4150, 4000, 3850, 3700, 3500, 3300}; db = 50; fitted = 1'b1; end
      5: begin b = '{5000, 5000, 5000, 5000, 5000, 5000}; db = 32767; fitted = 1'b1; end
      default: begin
        b[5] = 2600 + int'($urandom_range(0, 300));
        for (int i = 4; i >= 0; i--) b[i] = b[i+1] + int'($urandom_range(50, 300));
        db     = int'($urandom_range(0, 200));
        fitted = 1'($urandom_range(0, 1));
      end
    endcase
    foreach (band_regs[i]) begin
      write_reg(band_regs[i], {2'($urandom_range(0, 3)), b[i][12:0]});
    end
    write_reg(bgsc_pkg::REG_RATE_DEADBAND, db[14:0]);
    write_reg(bgsc_pkg::REG_VBUS_FITTED, {14'($urandom_range(0, 16383)), fitted});
  endtask

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no pending expectation");
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        chk("status", want.status, status_o);
        chk("charging", want.charging, charging_o);
        chk("usb_present", want.usb_present, usb_present_o);
        chk("batt_mv", want.batt_mv, batt_mv_o);
        chk("soc_reported", want.soc_reported, soc_reported_o);
        chk("note_usb_on", want.note_usb_on, note_usb_on_o);
        chk("note_usb_off", want.note_usb_off, note_usb_off_o);
        chk("note_low", want.note_low, note_low_o);
        chk("note_critical", want.note_critical, note_critical_o);
      end
    end
  end

  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    mode        = 0;
    mode_left   = 0;
    tick        = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        long_hold = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        tick++;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= (tick % 4 != 0);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    gauge_present_i = 1'b0;
    read_ok_i       = 1'b0;
    cell_mv_i       = '0;
    soc_centi_i     = '0;
    rate_centi_i    = '0;
    vbus_level_i    = 1'b0;

    band_cfg    = '{band_full_mv: 13'd4150, band_high_mv: 13'd4000, band_good_mv: 13'd3850,
                    band_medium_mv: 13'd3700, band_low_mv: 13'd3500,
                    band_critical_mv: 13'd3300, rate_deadband: 15'd50, vbus_pin_fitted: 1'b1};
    gauge_seen  = 1'b0;
    chg_state   = 1'b0;
    usb_state   = 1'b0;
    mv_held     = '0;
    soc_held    = '0;
    status_held = bgsc_pkg::ST_UNKNOWN;

    // Gauge search under the heuristic, then with the VBUS pin
    dir_tab.push_back('{1'b1, bgsc_pkg::REG_VBUS_FITTED, 15'd0, '0, 1'b0, '0});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(0, 1, 4000, 5000, 100, 0), 1'b1,
                        res(bgsc_pkg::ST_NOT_PRESENT, 0, 1, 0, 0, 0, 0, 0, 0)});
    dir_tab.push_back('{1'b1, bgsc_pkg::REG_VBUS_FITTED, 15'd1, '0, 1'b0, '0});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(0, 1, 4000, 5000, 100, 0), 1'b1,
                        res(bgsc_pkg::ST_NOT_PRESENT, 0, 0, 0, 0, 0, 0, 0, 0)});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(0, 0, 0, 0, 0, 1), 1'b1,
                        res(bgsc_pkg::ST_NOT_PRESENT, 0, 1, 0, 0, 0, 0, 0, 0)});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 0, 4100, 100, 0, 0), 1'b1,
                        res(bgsc_pkg::ST_NOT_PRESENT, 0, 1, 0, 0, 0, 0, 0, 0)});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 1, 3900, 16383, 0, 0), 1'b1,
                        res(bgsc_pkg::ST_GOOD, 0, 0, 3900, 10000, 0, 0, 0, 0)});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(0, 1, 3900, 0, 32767, 1), 1'b1,
                        res(bgsc_pkg::ST_CHARGING, 1, 1, 3900, 0, 1, 0, 0, 0)});
    // Deadband edges, topped-off clamp, ladder walk and low-cell drop
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 1, 4200, 9000, 50, 1), 1'b0, '0});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 1, 4200, 9000, -50, 1), 1'b0, '0});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 1, 4200, 9000, -51, 1), 1'b0, '0});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 1, 4200, 9000, 51, 1), 1'b0, '0});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 1, 4200, 9000, -32768, 1), 1'b0, '0});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 1, 3600, 2000, 0, 0), 1'b0, '0});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 1, 3400, 1500, 0, 0), 1'b0, '0});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 1, 3000, 500, 0, 0), 1'b0, '0});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 0, 8191, 16383, 0, 1), 1'b0, '0});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 1, 8191, 10000, 0, 0), 1'b0, '0});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 1, 2499, 100, 0, 0), 1'b1,
                        res(bgsc_pkg::ST_NOT_PRESENT, 0, 0, 2499, 100, 0, 0, 0, 0)});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 1, 2500, 0, 0, 0), 1'b0, '0});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 1, 1999, 0, 0, 0), 1'b0, '0});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 1, 0, 0, 0, 1), 1'b0, '0});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 1, 2100, 0, 0, 1), 1'b0, '0});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 1, 3850, 4000, 0, 0), 1'b0, '0});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 1, 3700, 3000, 0, 0), 1'b0, '0});
    dir_tab.push_back('{1'b0, NoIdx, '0, poll(1, 1, 4000, 6000, 0, 0), 1'b0, '0});

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_item(dir_tab[i].poll, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    for (int unsigned p = 0; p < NumPhases; p++) begin
      load_phase(p);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        if (p == 4 && n == 40) long_hold = 1'b1;
        if (p == 6 && n == 70) wait_drained();
        send_item(rand_poll(), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
